FILE: sv/assert_macros.svh
// assertion macros for the byte run-length encoder
// checked forms for simulation, empty forms for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: sv/brle_pkg.sv
// shared types and constants for the byte run-length encoder
// no dependencies
package brle_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam logic [BYTE_W-1:0] RUN_LIMIT = 8'd255;

  typedef struct packed {
    logic              last_pair;
    logic [BYTE_W-1:0] run_byte;
    logic [BYTE_W-1:0] run_length;
  } pair_t;

  typedef struct packed {
    logic [1:0] n;
    pair_t      slot0;
    pair_t      slot1;
  } push_t;

  typedef struct packed {
    logic room;
    logic nonempty;
  } queue_status_t;

endpackage

FILE: sv/byte_run_length_encoder_top.sv
// Byte run-length encoder: takes one byte per word on the input stream, with tlast on the
// final byte of a stream, and emits (count, value) pairs, tlast on the last pair. A byte is
// taken every cycle while the pair queue has room for two pairs; each byte yields zero, one
// or two pairs, and the output register drains one pair per cycle while out_ready is high;
// so one byte per cycle is sustained as long as fewer than one pair per byte is produced
// on average. Pairs pass through the pair queue into the output register. No clearing pass.
// depends on brle_pkg, brle_front, brle_queue, brle_back and assert_macros.svh
`include "assert_macros.svh"
module byte_run_length_encoder_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tlast,   // end_of_stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // run_byte, run_length
  output logic        m_axis_tlast    // last_pair
);
  import brle_pkg::*;

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  push_t         push;
  queue_status_t status;
  pair_t         head, out_pair;
  logic          pop;
  logic [CW-1:0] count;

  brle_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .data_byte    (s_axis_tdata),
    .end_of_stream(s_axis_tlast),
    .status       (status),
    .push         (push)
  );

  brle_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .status(status),
    .count (count)
  );

  brle_back u_back (
    .clk      (clk),
    .rst      (rst),
    .status   (status),
    .head     (head),
    .pop      (pop),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_pair (out_pair)
  );

  assign m_axis_tdata = {out_pair.run_byte, out_pair.run_length};
  assign m_axis_tlast = out_pair.last_pair;

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CW'(QUEUE_DEPTH))
  `ASSERT_IMPLIES(a_pop_nonempty, clk, rst, pop, count != '0)
  `ASSERT_IMPLIES(a_eos_pushes, clk, rst, s_axis_tvalid && s_axis_tready && s_axis_tlast,
                  push.n != 2'd0)
  `ASSERT_NEXT(a_push_fills, clk, rst, push.n != 2'd0 && !pop, count != '0)

endmodule

FILE: sv/brle_front.sv
// front end: accepts bytes, tracks the open run and classifies each byte
// produces zero, one or two pairs per word; uses brle_pkg
module brle_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             data_byte,
  input  logic                   end_of_stream,
  input  brle_pkg::queue_status_t status,
  output brle_pkg::push_t        push
);
  import brle_pkg::*;

  logic [BYTE_W-1:0] held_byte, held_byte_next;
  logic [BYTE_W-1:0] held_length, held_length_next;
  logic              run_open, run_open_next;
  logic              accept;
  logic              flush;
  pair_t             flush_pair, final_pair;

  assign in_ready = status.room;
  assign accept   = in_valid && in_ready;

  always_comb begin
    flush            = 1'b0;
    held_byte_next   = data_byte;
    held_length_next = 8'd1;
    run_open_next    = 1'b1;
    if (run_open && data_byte == held_byte && held_length < RUN_LIMIT) begin
      held_length_next = held_length + 8'd1;
    end else if (run_open) begin
      flush = 1'b1;
    end
    flush_pair.run_length = held_length;
    flush_pair.run_byte   = held_byte;
    flush_pair.last_pair  = 1'b0;
    final_pair.run_length = held_length_next;
    final_pair.run_byte   = held_byte_next;
    final_pair.last_pair  = 1'b1;
    push.slot0 = flush ? flush_pair : final_pair;
    push.slot1 = final_pair;
    push.n     = 2'd0;
    if (accept) begin
      push.n = {1'b0, flush} + {1'b0, end_of_stream};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_byte   <= '0;
      held_length <= '0;
      run_open    <= 1'b0;
    end else if (accept) begin
      if (end_of_stream) begin
        held_byte   <= '0;
        held_length <= '0;
        run_open    <= 1'b0;
      end else begin
        held_byte   <= held_byte_next;
        held_length <= held_length_next;
        run_open    <= run_open_next;
      end
    end
  end

endmodule

FILE: sv/brle_queue.sv
// pair queue between front and back: two writes and one read per cycle
// depth must be a power of two; uses brle_pkg
module brle_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  brle_pkg::push_t               push,
  input  logic                          pop,
  output brle_pkg::pair_t               head,
  output brle_pkg::queue_status_t       status,
  output logic [$clog2(DEPTH+1)-1:0]    count
);
  import brle_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  pair_t            entries [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count_next;

  assign head            = entries[rd_ptr];
  assign status.nonempty = count != '0;
  assign status.room     = count <= CW'(DEPTH - 2);
  assign count_next      = count + CW'(push.n) - CW'(pop);

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      entries[wr_ptr] <= push.slot0;
    end
    if (push.n == 2'd2) begin
      entries[wr_ptr + PW'(1)] <= push.slot1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push.n);
      rd_ptr <= rd_ptr + PW'(pop);
      count  <= count_next;
    end
  end

endmodule

FILE: sv/brle_back.sv
// back end: output register that drains the pair queue onto the stream
// uses brle_pkg
module brle_back (
  input  logic                    clk,
  input  logic                    rst,
  input  brle_pkg::queue_status_t status,
  input  brle_pkg::pair_t         head,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output brle_pkg::pair_t         out_pair
);
  import brle_pkg::*;

  assign pop = status.nonempty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= status.nonempty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_pair <= head;
    end
  end

endmodule

FILE: verif/byte_run_length_encoder_top_test.sv
// testbench for byte_run_length_encoder_top: random byte streams with random stalls on both sides
// an in-bench run encoder predicts the (count, value) pairs and checks each output word
// depends on brle_pkg and byte_run_length_encoder_top
module byte_run_length_encoder_top_test;
  import brle_pkg::*;

  class run_encoder_model;
    logic [7:0] held_byte;
    logic [7:0] held_length;
    bit         run_open;
    pair_t      pending_pairs[$];
    int         mismatches;

    function new();
      held_byte   = '0;
      held_length = '0;
      run_open    = 1'b0;
      mismatches  = 0;
    endfunction

    function void push_pair(logic [7:0] len, logic [7:0] val, logic last);
      pair_t p;
      p.run_length = len;
      p.run_byte   = val;
      p.last_pair  = last;
      pending_pairs.push_back(p);
    endfunction

    function void take_byte(logic [7:0] b, logic eos);
      if (!run_open) begin
        held_byte   = b;
        held_length = 8'd1;
        run_open    = 1'b1;
      end else if (b == held_byte && held_length < RUN_LIMIT) begin
        held_length = held_length + 8'd1;
      end else begin
        push_pair(held_length, held_byte, 1'b0);
        held_byte   = b;
        held_length = 8'd1;
      end
      if (eos) begin
        push_pair(held_length, held_byte, 1'b1);
        held_byte   = '0;
        held_length = '0;
        run_open    = 1'b0;
      end
    endfunction

    function void match_pair(logic [15:0] word, logic last);
      pair_t want;
      if (pending_pairs.size() == 0) begin
        $error("unexpected pair: run_length %0d run_byte 0x%02h last_pair %0d",
               word[7:0], word[15:8], last);
        mismatches++;
        return;
      end
      want = pending_pairs.pop_front();
      if (word[7:0] !== want.run_length) begin
        $error("run_length: expected %0d, got %0d", want.run_length, word[7:0]);
        mismatches++;
      end
      if (word[15:8] !== want.run_byte) begin
        $error("run_byte: expected 0x%02h, got 0x%02h", want.run_byte, word[15:8]);
        mismatches++;
      end
      if (last !== want.last_pair) begin
        $error("last_pair: expected %0d, got %0d", want.last_pair, last);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  run_encoder_model encoder = new();
  int bytes_sent  = 0;
  bit steady      = 1'b0;
  bit hold_req    = 1'b0;

  always #5 clk = ~clk;

  byte_run_length_encoder_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  task automatic send_byte(input logic [7:0] b, input logic eos);
    while (!steady && $urandom_range(0, 99) < 8) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eos;
    do @(posedge clk); while (!s_axis_tready);
    encoder.take_byte(b, eos);
    bytes_sent++;
  endtask

  // a run of len copies of b; closes flags the final byte as end of stream
  task automatic send_run(input logic [7:0] b, input int len, input bit closes);
    for (int i = 0; i < len; i++) begin
      send_byte(b, closes && (i == len - 1));
    end
  endtask

  // output side: checks accepted words, random stalls and one long hold-off
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        encoder.match_pair(m_axis_tdata, m_axis_tlast);
      end
      if (hold_req && !hold_done) begin
        hold_left = 300;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!steady && $urandom_range(0, 99) < 8) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    int         runs;
    int         len;
    int         r;
    int         waited;
    logic [7:0] b;
    logic [7:0] prev_b;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single-byte streams at both extremes
    send_run(8'h00, 1, 1'b1);
    send_run(8'hFF, 1, 1'b1);
    // short runs, a change of byte and a run closed by end of stream
    send_run(8'h55, 2, 1'b0);
    send_run(8'hAA, 1, 1'b1);
    send_run(8'hAA, 3, 1'b1);
    send_run(8'h01, 1, 1'b0);
    send_run(8'h02, 1, 1'b0);
    send_run(8'h03, 1, 1'b1);
    send_run(8'hFF, 2, 1'b0);
    send_run(8'h00, 2, 1'b1);
    send_run(8'h80, 1, 1'b0);
    send_run(8'h7F, 1, 1'b0);
    send_run(8'h80, 2, 1'b1);

    // runs at the length limit: exactly full, one over, two full
    send_run(8'($urandom_range(0, 255)), 255, 1'b1);
    send_run(8'($urandom_range(0, 255)), 256, 1'b1);
    send_run(8'($urandom_range(0, 255)), 510, 1'b1);

    prev_b     = '0;
    while (bytes_sent < 1600) begin
      runs = $urandom_range(1, 8);
      for (int k = 0; k < runs; k++) begin
        r = $urandom_range(0, 199);
        if (r == 0) len = $urandom_range(250, 260);
        else if (r < 40) len = $urandom_range(5, 20);
        else len = $urandom_range(1, 4);
        if ($urandom_range(0, 3) == 0) b = prev_b;
        else b = 8'($urandom_range(0, 255));
        prev_b = b;
        send_run(b, len, k == runs - 1);
        if (bytes_sent > 1100 && !hold_req) hold_req = 1'b1;
        steady = (bytes_sent > 1250 && bytes_sent < 1550);
      end
    end
    steady = 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;

    waited = 0;
    while (encoder.pending_pairs.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (encoder.mismatches == 0 && encoder.pending_pairs.size() == 0) begin
      $display("byte_run_length_encoder_top_test: done, clean");
    end else begin
      if (encoder.pending_pairs.size() != 0) begin
        $error("%0d pairs never arrived", encoder.pending_pairs.size());
      end
      $display("byte_run_length_encoder_top_test: done, errors");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("byte_run_length_encoder_top_test: done, errors");
    $finish;
  end

endmodule
